@@ rtl/nfi_pkg.sv @@
// Package for the Newton forward-difference interpolator: payload types, codes and shared constants.
package nfi_pkg;

    localparam int WORD_W = 64;
    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] DIV_STEPS = 7'd64;
    localparam logic [WORD_W-1:0] BIG_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_POINTS = 2'd1;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] query_x;
    } item_t;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic              start;
        logic              div;
        logic [STEP_W-1:0] steps;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } unit_sts_t;

endpackage

@@ rtl/nfi_serial_unit.sv @@
// Shared bit-serial unit: saturating shift-add multiply or restoring divide, one bit per cycle.
module nfi_serial_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nfi_pkg::unit_ctl_t         ctl,
    input  logic [nfi_pkg::WORD_W-1:0] opa,
    input  logic [nfi_pkg::WORD_W-1:0] opb,
    output nfi_pkg::unit_sts_t         sts,
    output logic [nfi_pkg::WORD_W-1:0] result
);
    import nfi_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] shb_reg, shb_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;

    logic              bit_in;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   addend;
    logic [WORD_W:0]   sum;
    logic              ge;

    // In divide mode the adder subtracts the divisor; in multiply mode it adds the multiplicand.
    always_comb
    begin
        bit_in  = shb_reg[WORD_W-1];
        shifted = {acc_reg[WORD_W-2:0], ctl.div ? bit_in : 1'b0};
        if (ctl.div)
        begin
            addend = ~{1'b0, opa};
        end
        else
        begin
            addend = {1'b0, bit_in ? opa : {WORD_W{1'b0}}};
        end
        sum = {1'b0, shifted} + addend + {{WORD_W{1'b0}}, ctl.div};
        ge  = ~sum[WORD_W];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        shb_next  = shb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (ctl.start)
        begin
            acc_next  = '0;
            shb_next  = opb;
            cnt_next  = '0;
            busy_next = 1'b1;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (ctl.div)
            begin
                acc_next = ge ? sum[WORD_W-1:0] : shifted;
                shb_next = {shb_reg[WORD_W-2:0], ge};
            end
            else
            begin
                // The partial product only grows, so an overflow is sticky.
                ovf_next = ovf_reg | (sum > {1'b0, BIG_LIMIT});
                if (!ovf_next)
                begin
                    acc_next = sum[WORD_W-1:0];
                end
                shb_next = {shb_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == ctl.steps - STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        shb_reg <= shb_next;
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign result   = ctl.div ? shb_reg : (ovf_reg ? BIG_LIMIT : acc_reg);

endmodule

@@ rtl/newton_forward_interpolator_core.sv @@
// Newton forward-difference interpolator top level: point store, difference table and sequencer.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  item     | item_valid / item_ready     | op, sample_x, sample_y, query_x
//  result   | result_valid / result_ready | interpolated, status (evaluate only)
//
// Clear and load complete in the idle state. An evaluate with two or more points runs, for each
// difference order, the bit-serial multiply, divide and multiply passes of the shared unit.
// rst_n clears the point count, the sequencer and the result valid flag; stored points are
// not cleared. item_ready is low while an evaluation runs; a finished result waiting on
// result_ready does not block new items until the next result is ready to be stored.
module newton_forward_interpolator_core #(
    parameter int MAX_POINTS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  nfi_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output nfi_pkg::result_t result
);
    import nfi_pkg::*;

    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DW   = 32 + MAX_POINTS - 1;
    localparam int MB   = (DW > 33) ? DW : 33;
    localparam int DENW = 33 + CW;
    localparam int X1   = (MAX_POINTS > 1) ? 1 : 0;
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(MB);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_DIV1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            k_reg, k_next;
    logic                     launch_reg, launch_next;
    logic                     clamp_reg, clamp_next;
    logic                     rv_reg, rv_next;
    result_t                  res_reg, res_next;
    result_t                  pend_reg, pend_next;

    logic signed [31:0]       x_reg [MAX_POINTS];
    logic signed [31:0]       y_reg [MAX_POINTS];
    logic signed [31:0]       x_next [MAX_POINTS];
    logic signed [31:0]       y_next [MAX_POINTS];
    logic signed [DW-1:0]     d_reg [MAX_POINTS];
    logic signed [DW-1:0]     d_next [MAX_POINTS];
    logic signed [31:0]       q_reg, q_next;
    logic [32:0]              hmag_reg, hmag_next;
    logic                     hneg_reg, hneg_next;
    logic [DENW-1:0]          den_reg, den_next;
    logic [WORD_W-1:0]        pmag_reg, pmag_next;
    logic                     pneg_reg, pneg_next;
    logic                     sgn_reg, sgn_next;
    logic signed [WORD_W-1:0] acc_reg, acc_next;

    unit_ctl_t                ctl;
    unit_sts_t                sts;
    logic [WORD_W-1:0]        opa;
    logic [WORD_W-1:0]        opb;
    logic [WORD_W-1:0]        ures;

    logic signed [32:0]       h_s;
    logic signed [32:0]       qx_s;
    logic [32:0]              qx_mag;
    logic [DW-1:0]            d0_mag;
    logic [CW-1:0]            km1;
    logic [CW-1:0]            k_inc;
    logic [WORD_W-1:0]        term_mag;
    logic signed [WORD_W-1:0] term_s;
    logic signed [WORD_W-1:0] sum_s;
    logic [WORD_W-1:0]        sum_mag;

    nfi_serial_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .opa    (opa),
        .opb    (opb),
        .sts    (sts),
        .result (ures)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

    always_comb
    begin
        km1      = k_reg - CW'(1);
        k_inc    = k_reg + CW'(1);
        h_s      = 33'(x_reg[X1]) - 33'(x_reg[0]);
        qx_s     = 33'(q_reg) - 33'(x_reg[km1[IW-1:0]]);
        qx_mag   = qx_s[32] ? 33'(-qx_s) : 33'(qx_s);
        d0_mag   = d_reg[0][DW-1] ? DW'(-d_reg[0]) : DW'(d_reg[0]);
        term_mag = (ures + (WORD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        term_s   = sgn_reg ? -$signed(term_mag) : $signed(term_mag);
        sum_s    = acc_reg + term_s;
        sum_mag  = sum_s[WORD_W-1] ? WORD_W'(-sum_s) : WORD_W'(sum_s);
    end

    // Unit operands: the running factor times (q - x), divided by k*h, then times the difference.
    always_comb
    begin
        ctl.start = 1'b0;
        ctl.div   = (state_reg == S_DIV1);
        ctl.steps = ctl.div ? DIV_STEPS : MUL_STEPS;
        opa       = ctl.div ? WORD_W'(den_reg) : pmag_reg;
        opb       = '0;
        unique case (state_reg)
            S_MUL1:
            begin
                ctl.start = !launch_reg;
                opb       = WORD_W'(qx_mag) << (WORD_W - MB);
            end
            S_DIV1:
            begin
                ctl.start = !launch_reg;
                opb       = pmag_reg + WORD_W'(den_reg >> 1);
            end
            S_MUL2:
            begin
                ctl.start = !launch_reg;
                opb       = WORD_W'(d0_mag) << (WORD_W - MB);
            end
            default:
            begin
                ctl.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        launch_next = launch_reg;
        clamp_next  = clamp_reg;
        rv_next     = rv_reg;
        res_next    = res_reg;
        pend_next   = pend_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        q_next      = q_reg;
        hmag_next   = hmag_reg;
        hneg_next   = hneg_reg;
        den_next    = den_reg;
        pmag_next   = pmag_reg;
        pneg_next   = pneg_reg;
        sgn_next    = sgn_reg;
        acc_next    = acc_reg;

        if (rv_reg && result_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.op)
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (cnt_reg < CW'(MAX_POINTS))
                            begin
                                x_next[cnt_reg[IW-1:0]] = item.sample_x;
                                y_next[cnt_reg[IW-1:0]] = item.sample_y;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_EVAL:
                        begin
                            q_next     = item.query_x;
                            state_next = S_START;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            S_START:
            begin
                state_next = S_OUT;
                if (cnt_reg == '0)
                begin
                    pend_next.interpolated = '0;
                    pend_next.status       = STATUS_NO_POINTS;
                end
                else if (cnt_reg == CW'(1))
                begin
                    pend_next.interpolated = y_reg[0];
                    pend_next.status       = STATUS_OK;
                end
                else if (h_s == '0)
                begin
                    pend_next.interpolated = '0;
                    pend_next.status       = STATUS_ZERO_STEP;
                end
                else
                begin
                    for (int i = 0; i < MAX_POINTS; i++)
                    begin
                        d_next[i] = DW'(y_reg[i]);
                    end
                    acc_next   = WORD_W'(y_reg[0]);
                    pmag_next  = WORD_W'(1) << FRAC_BITS;
                    pneg_next  = 1'b0;
                    clamp_next = 1'b0;
                    k_next     = CW'(1);
                    hmag_next  = h_s[32] ? 33'(-h_s) : 33'(h_s);
                    hneg_next  = h_s[32];
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // One order of the difference table; d[0] then holds the k-th difference.
                for (int i = 0; i < MAX_POINTS - 1; i++)
                begin
                    d_next[i] = d_reg[i+1] - d_reg[i];
                end
                den_next    = DENW'(hmag_reg) * DENW'(k_reg);
                launch_next = 1'b0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                if (!launch_reg)
                begin
                    launch_next = 1'b1;
                    sgn_next    = pneg_reg ^ qx_s[32];
                end
                else if (sts.done)
                begin
                    // The product magnitude becomes the dividend of the next pass.
                    pmag_next   = ures;
                    clamp_next  = clamp_reg | sts.ovf;
                    launch_next = 1'b0;
                    state_next  = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (!launch_reg)
                begin
                    launch_next = 1'b1;
                end
                else if (sts.done)
                begin
                    // The rounded quotient never exceeds the clamp limit here.
                    pmag_next   = ures;
                    pneg_next   = sgn_reg ^ hneg_reg;
                    launch_next = 1'b0;
                    state_next  = S_MUL2;
                end
            end
            S_MUL2:
            begin
                if (!launch_reg)
                begin
                    launch_next = 1'b1;
                    sgn_next    = pneg_reg ^ d_reg[0][DW-1];
                end
                else if (sts.done)
                begin
                    clamp_next  = clamp_reg | sts.ovf;
                    launch_next = 1'b0;
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                if (sum_mag > BIG_LIMIT)
                begin
                    clamp_next = 1'b1;
                    acc_next   = sum_s[WORD_W-1] ? -$signed(BIG_LIMIT) : $signed(BIG_LIMIT);
                end
                else
                begin
                    acc_next = sum_s;
                end
                k_next     = k_inc;
                state_next = (k_inc < cnt_reg) ? S_DIFF : S_FIN;
            end
            S_FIN:
            begin
                pend_next.status = clamp_reg ? STATUS_SATURATED : STATUS_OK;
                if (acc_reg > 64'sd2147483647)
                begin
                    pend_next.interpolated = 32'sh7FFF_FFFF;
                    pend_next.status       = STATUS_SATURATED;
                end
                else if (acc_reg < -64'sd2147483648)
                begin
                    pend_next.interpolated = 32'sh8000_0000;
                    pend_next.status       = STATUS_SATURATED;
                end
                else
                begin
                    pend_next.interpolated = acc_reg[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg || result_ready)
                begin
                    res_next   = pend_reg;
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            k_reg      <= '0;
            launch_reg <= 1'b0;
            clamp_reg  <= 1'b0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            launch_reg <= launch_next;
            clamp_reg  <= clamp_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        hmag_reg <= hmag_next;
        hneg_reg <= hneg_next;
        den_reg  <= den_next;
        pmag_reg <= pmag_next;
        pneg_reg <= pneg_next;
        sgn_reg  <= sgn_next;
        acc_reg  <= acc_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> (state_reg == S_MUL1 || state_reg == S_DIV1 || state_reg == S_MUL2))
        else $error("unit started outside an arithmetic step");

    a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> launch_reg)
        else $error("unit finished with no operation launched");

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIFF) |-> (k_reg != '0 && k_reg < cnt_reg))
        else $error("difference order out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rv_reg && !result_ready) |=> $stable(res_reg))
        else $error("pending result overwritten");

endmodule

@@ tb/newton_forward_interpolator_core_tb.sv @@
// Testbench for the Newton forward-difference interpolator core: random and directed transfers checked against a predictor.
module newton_forward_interpolator_core_tb;
    import nfi_pkg::*;

    localparam longint CLAMP62 = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 200000;

    class interp_scoreboard;
        longint xs[6];
        longint ys[6];
        int npts;
        bit clamped;
        result_t pending[$];
        int errors;

        function new();
            npts = 0;
            errors = 0;
        endfunction

        function longint clamp_mag(longint unsigned m, bit neg);
            if (m > CLAMP62)
            begin
                clamped = 1;
                m = CLAMP62;
            end
            return neg ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned magnitude(longint a);
            return a < 0 ? -a : a;
        endfunction

        function longint mul_sat(longint a, longint b);
            longint unsigned ua, ub;
            bit neg;
            ua = magnitude(a);
            ub = magnitude(b);
            neg = (a < 0) != (b < 0);
            if (ua == 0 || ub == 0)
                return 0;
            if (ua > CLAMP62 / ub)
                return clamp_mag(CLAMP62 + 1, neg);
            return neg ? -longint'(ua * ub) : longint'(ua * ub);
        endfunction

        function longint div_round(longint a, longint b);
            longint unsigned ua, ub;
            ua = magnitude(a);
            ub = magnitude(b);
            return clamp_mag((ua + ub / 2) / ub, (a < 0) != (b < 0));
        endfunction

        function longint add_sat(longint a, longint b);
            longint s;
            s = a + b;
            return clamp_mag(magnitude(s), s < 0);
        endfunction

        function result_t interpolate(longint q);
            longint d[6];
            longint delta[6];
            longint h, p, acc;
            result_t r;
            r.interpolated = 0;
            if (npts == 0)
            begin
                r.status = STATUS_NO_POINTS;
                return r;
            end
            clamped = 0;
            for (int i = 0; i < npts; i++)
                d[i] = ys[i];
            delta[0] = d[0];
            for (int k = 1; k < npts; k++)
            begin
                for (int i = 0; i + k < npts; i++)
                    d[i] = d[i + 1] - d[i];
                delta[k] = d[0];
            end
            acc = delta[0];
            if (npts >= 2)
            begin
                h = xs[1] - xs[0];
                if (h == 0)
                begin
                    r.status = STATUS_ZERO_STEP;
                    return r;
                end
                p = 64'sd1 << 16;
                for (int k = 1; k < npts; k++)
                begin
                    p = div_round(mul_sat(p, q - xs[k - 1]), h * k);
                    acc = add_sat(acc, div_round(mul_sat(p, delta[k]), 64'sd1 << 16));
                end
            end
            if (acc > 64'sd2147483647)
            begin
                acc = 64'sd2147483647;
                clamped = 1;
            end
            else if (acc < -64'sd2147483648)
            begin
                acc = -64'sd2147483648;
                clamped = 1;
            end
            r.interpolated = acc[31:0];
            r.status = clamped ? STATUS_SATURATED : STATUS_OK;
            return r;
        endfunction

        function void note_item(item_t it);
            case (it.op)
                OP_CLEAR: npts = 0;
                OP_LOAD:
                    if (npts < 6)
                    begin
                        xs[npts] = it.sample_x;
                        ys[npts] = it.sample_y;
                        npts++;
                    end
                OP_EVAL: pending.push_back(interpolate(it.query_x));
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h/%0d", $time, got.interpolated, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.interpolated !== want.interpolated)
            begin
                $display("%0t: interpolated expected %h actual %h", $time,
                         want.interpolated, got.interpolated);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;

    interp_scoreboard sb;
    bit calm;
    int idle_cycles;

    newton_forward_interpolator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    initial
    begin
        sb = new();
        calm = 0;
        rst_n = 0;
        item_valid = 0;
        item = '0;
        result_ready = 0;
    end

    // Checker and watchdog sample at the edge; the accept terms are from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    // Receiver side: random stall bursts unless in the calm tail.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                result_ready <= 0;
                repeat (n) @(posedge clk);
            end
            result_ready <= 1;
        end
    end

    // Valid stays high into the next item unless an idle burst comes between them.
    task automatic send_item(logic [1:0] op, logic [31:0] sx, logic [31:0] sy, logic [31:0] qx);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 19);
            item_valid <= 0;
            repeat (n) @(posedge clk);
        end
        item_valid <= 1;
        item.op <= op;
        item.sample_x <= sx;
        item.sample_y <= sy;
        item.query_x <= qx;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    // Cleared, evenly spaced set of zero to seven points, spacing sometimes zero or random, then one to four queries.
    task automatic send_set();
        int n;
        int x0, h;
        n = $urandom_range(0, 7);
        x0 = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
        h = $urandom_range(0, 7) == 0 ? 0 : $signed($urandom_range(1, 2 << 16)) - (1 << 16);
        if ($urandom_range(0, 9) == 0)
            h = $urandom();
        send_item(OP_CLEAR, $urandom(), $urandom(), $urandom());
        for (int i = 0; i < n; i++)
            send_item(OP_LOAD, x0 + i * h,
                      $urandom_range(0, 3) == 0 ? rand_word()
                                                : $signed($urandom_range(0, 16 << 16)) - (8 << 16),
                      $urandom());
        repeat ($urandom_range(1, 4))
            send_item(OP_EVAL, $urandom(), $urandom(),
                      $urandom_range(0, 3) == 0 ? rand_word() : x0 + $signed($urandom_range(0, 6))
                                                  * h + $signed($urandom_range(0, 1 << 16)));
    endtask

    initial
    begin
        int sent;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty store, one point, zero spacing, full store with extremes, op 3, three-point set.
        send_item(OP_EVAL, 0, 0, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_item(OP_EVAL, 0, 0, 32'h8000_0000);
        send_item(OP_LOAD, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(OP_EVAL, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < 7; i++)
            send_item(OP_LOAD, i << 16, (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000, 0);
        send_item(OP_EVAL, 0, 0, 32'h0002_8000);
        send_item(OP_EVAL, 0, 0, 32'h7FFF_FFFF);
        send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 0, 1 << 16, 0);
        send_item(OP_LOAD, 1 << 16, 3 << 16, 0);
        send_item(OP_LOAD, 2 << 16, 7 << 16, 0);
        send_item(OP_EVAL, 0, 0, 32'h0001_8000);

        sent = 0;
        while (sent < 480)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
                sent++;
            end
            else
            begin
                send_set();
                sent += 6;
            end
            if (sent > 420)
                calm = 1;
        end
        item_valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
